[src/prex_pkg.sv]
package prex_pkg;

    // Byte codes that end a run
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // Printable range and the tab exception
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    // Configuration register indexes
    localparam logic REG_MIN_RUN_LENGTH = 1'b0;
    localparam logic REG_SHOW_OFFSET    = 1'b1;

    localparam int          CFG_W           = 7;
    localparam logic [6:0]  MIN_RUN_RESET   = 7'd4;

    // Controller to datapath
    typedef struct packed {
        logic take;     // input word accepted this cycle
        logic rd_en;    // read run buffer at current index
        logic rd_next;  // advance read index
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit;     // accepted word starts an emission
        logic last;     // current read index is the final character
    } dp_stat_t;

endpackage

[src/prex_ctrl.sv]
module prex_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  prex_pkg::dp_stat_t stat,
    output prex_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_SCAN = 3'b001,
        ST_READ = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.take    = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.rd_next = 1'b0;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        unique case (state_reg)
            ST_SCAN:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid && stat.emit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (stat.last)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SCAN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/prex_dp.sv]
module prex_dp #(
    parameter int MAX_RUN = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic [7:0]         in_byte,
    output logic [7:0]         out_char,
    output logic [31:0]        start_offset,
    output logic               run_end,
    input  prex_pkg::dp_cmd_t  cmd,
    output prex_pkg::dp_stat_t stat
);

    localparam int IDX_W = $clog2(MAX_RUN);
    localparam int LEN_W = $clog2(MAX_RUN + 1);

    logic [7:0]       run_buffer [MAX_RUN];
    logic [LEN_W-1:0] run_length_reg;
    logic [LEN_W-1:0] run_length_next;
    logic [31:0]      byte_position_reg;
    logic [6:0]       min_run_length_reg;
    logic             show_offset_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic [31:0]      offset_reg;
    logic [7:0]       rd_data_reg;

    logic             is_term;
    logic             is_print;
    logic             is_full;
    logic             long_enough;
    logic [7:0]       min_len;
    logic [7:0]       len_ext;
    logic [31:0]      run_start;
    logic [IDX_W-1:0] len_idx;

    // Byte classification
    assign is_term  = (in_byte == prex_pkg::CHAR_NUL) || (in_byte == prex_pkg::CHAR_LF)
                   || (in_byte == prex_pkg::CHAR_CR);
    assign is_print = ((in_byte >= prex_pkg::CHAR_SPACE) && (in_byte < prex_pkg::CHAR_DEL))
                   || (in_byte == prex_pkg::CHAR_TAB);

    // Emission decision; a zero minimum acts as one
    assign min_len     = (min_run_length_reg == 7'd0) ? 8'd1 : {1'b0, min_run_length_reg};
    assign len_ext     = 8'(run_length_reg);
    assign long_enough = len_ext >= min_len;
    assign is_full     = is_print && (run_length_reg == LEN_W'(MAX_RUN - 1));
    assign len_idx     = run_length_reg[IDX_W-1:0];
    assign stat.emit   = (is_term && long_enough) || is_full;
    assign stat.last   = rd_idx_reg == last_idx_reg;

    // Both emission cases start at current position minus stored length
    assign run_start = byte_position_reg - 32'(run_length_reg);

    // Run length update
    always_comb
    begin
        if (is_print && !is_full)
        begin
            run_length_next = run_length_reg + LEN_W'(1);
        end
        else
        begin
            run_length_next = '0;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg     <= '0;
            byte_position_reg  <= '0;
            min_run_length_reg <= prex_pkg::MIN_RUN_RESET;
            show_offset_reg    <= 1'b0;
            rd_idx_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    prex_pkg::REG_MIN_RUN_LENGTH: min_run_length_reg <= cfg_data;
                    prex_pkg::REG_SHOW_OFFSET:    show_offset_reg    <= cfg_data[0];
                    default:                      ;
                endcase
            end
            if (cmd.take)
            begin
                run_length_reg    <= run_length_next;
                byte_position_reg <= byte_position_reg + 32'd1;
                if (stat.emit)
                begin
                    rd_idx_reg <= '0;
                end
            end
            else if (cmd.rd_next)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
    end

    // Emission descriptor
    always_ff @(posedge clk)
    begin
        if (cmd.take && stat.emit)
        begin
            offset_reg   <= show_offset_reg ? run_start : 32'd0;
            last_idx_reg <= is_full ? len_idx : (len_idx - IDX_W'(1));
        end
    end

    // Run buffer: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.take && is_print)
        begin
            run_buffer[len_idx] <= in_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= run_buffer[rd_idx_reg];
        end
    end

    assign out_char     = rd_data_reg;
    assign start_offset = offset_reg;
    assign run_end      = stat.last;

    // Buffer is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> !cmd.rd_en)
        else $error("run buffer written during emission");

    // Stored length always leaves room for one more byte
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_length_reg <= LEN_W'(MAX_RUN - 1))
        else $error("run length out of range");

    // Emission starts from the first character
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && stat.emit) |=> (rd_idx_reg == '0))
        else $error("emission did not restart read index");

    // Read index never steps past the final character
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_next |-> (rd_idx_reg != last_idx_reg))
        else $error("read index passed end of run");

endmodule

[src/printable_run_extractor.sv]
// Printable run extractor: scans one byte per accepted word and collects runs of
// printable characters (space to tilde, and tab). A NUL, LF or CR ends a run, which is
// sent out one character per output word if it is at least min_run_length long (zero
// counts as one); any other byte drops the run. A run reaching MAX_RUN characters is
// sent at once. start_offset gives the run's first byte position (mod 2^32) when
// show_offset is set, else zero; run_end marks the last character. A byte that
// triggers no output leaves in_stall low. A byte that triggers a run holds in_stall
// high after it is taken until the run's last character is sent, also while out_stall
// holds the output: each character needs a registered run-buffer read and then the
// output word. A run still open at end of input is never sent.
module printable_run_extractor #(
    parameter int MAX_RUN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic [31:0] start_offset,
    output logic        run_end
);

    prex_pkg::dp_cmd_t  cmd;
    prex_pkg::dp_stat_t stat;

    // Sequencer
    prex_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Run buffer, counters and output registers
    prex_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_byte      (in_byte),
        .out_char     (out_char),
        .start_offset (start_offset),
        .run_end      (run_end),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
